[src/octc_pkg.sv]
// ----------------------------------------------------------------------------
// octc_pkg
// Shared types and constants of the control-message dedup filter.
// ----------------------------------------------------------------------------
package octc_pkg;

    localparam int IDX_BITS   = 7;
    localparam int LEVEL_BITS = 7;
    localparam int TIME_BITS  = 32;
    localparam int PERIOD_BITS = 16;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 88;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd200;

    // Address characters and lengths
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] LEN_ONE_DIGIT = 8'd7;
    localparam logic [7:0] LEN_TWO_DIGIT = 8'd8;
    localparam logic [7:0] ARGS_EXPECTED = 8'd1;

    // Decoded message: address, argument check and quantised level.
    typedef struct packed {
        logic                  valid;
        logic [IDX_BITS-1:0]   idx;
        logic [LEVEL_BITS-1:0] level;
    } decode_t;

    // Table entry as seen by the filter stage.
    typedef struct packed {
        logic                  valid;
        logic [LEVEL_BITS-1:0] level;
        logic [TIME_BITS-1:0]  stamp;
    } lookup_t;

endpackage

[src/octc_decode.sv]
// ----------------------------------------------------------------------------
// octc_decode
// Address check, index extraction and value quantisation of one message.
// ----------------------------------------------------------------------------
module octc_decode #(
    parameter int TABLE_SIZE = 128,
    parameter int LEVELS     = 128
) (
    input  logic [63:0]          addr_bytes,
    input  logic [7:0]           addr_len,
    input  logic [7:0]           arg_count,
    input  logic                 arg_is_float,
    input  logic signed [31:0]   value_q16,
    output octc_pkg::decode_t    msg
);
    import octc_pkg::*;

    localparam logic [LEVEL_BITS-1:0] LVL_MAX = LEVEL_BITS'(LEVELS - 1);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    logic [7:0]              ch [8];
    logic [3:0]              d_hi;
    logic [3:0]              d_lo;
    logic [IDX_BITS-1:0]     n;
    logic                    prefix_ok;
    logic                    digits_ok;
    logic                    len_ok;
    logic signed [39:0]      prod;
    logic signed [39:0]      rounded;
    logic [22:0]             q;
    logic [LEVEL_BITS-1:0]   lvl;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ch[i] = addr_bytes[63 - 8*i -: 8];
        end
    end

    assign d_hi = 4'(ch[6] - CH_0);
    assign d_lo = 4'(ch[7] - CH_0);

    assign len_ok    = (addr_len == LEN_ONE_DIGIT) || (addr_len == LEN_TWO_DIGIT);
    assign prefix_ok = (ch[0] == CH_SLASH) && (ch[1] == CH_M) && (ch[2] == CH_I)
                    && (ch[3] == CH_E) && (ch[4] == CH_M) && (ch[5] == CH_SLASH);
    assign digits_ok = is_digit(ch[6])
                    && ((addr_len == LEN_ONE_DIGIT) || is_digit(ch[7]));

    // Two digits: tens times ten as a pair of shifts, plus units.
    always_comb
    begin
        if (addr_len == LEN_TWO_DIGIT)
        begin
            n = IDX_BITS'({d_hi, 3'b000}) + IDX_BITS'({d_hi, 1'b0}) + IDX_BITS'(d_lo);
        end
        else
        begin
            n = IDX_BITS'(d_hi);
        end
    end

    // Level = (LEVELS-1)*v rounded half up, clamped to 0..LEVELS-1.
    assign prod    = value_q16 * $signed({1'b0, LVL_MAX});
    assign rounded = prod + 40'sd32768;
    assign q       = rounded[38:16];

    always_comb
    begin
        priority if (rounded[39])
        begin
            lvl = '0;
        end
        else if (q > 23'(LVL_MAX))
        begin
            lvl = LVL_MAX;
        end
        else
        begin
            lvl = q[LEVEL_BITS-1:0];
        end
    end

    always_comb
    begin
        msg.valid = (arg_count == ARGS_EXPECTED) && arg_is_float && len_ok && prefix_ok
                 && digits_ok && ({1'b0, n} < 8'(TABLE_SIZE));
        msg.idx   = msg.valid ? n : '0;
        msg.level = msg.valid ? lvl : '0;
    end

endmodule

[src/octc_table.sv]
// ----------------------------------------------------------------------------
// octc_table
// Per-index store of last forwarded level and time, with valid bits and a
// bypass for a read that meets a write to the same entry.
// ----------------------------------------------------------------------------
module octc_table #(
    parameter int TABLE_SIZE = 128,
    parameter int IDX_W      = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [IDX_W-1:0]                    rd_addr,
    input  logic                                wr_en,
    input  logic [IDX_W-1:0]                    wr_addr,
    input  logic [octc_pkg::LEVEL_BITS-1:0]     wr_level,
    input  logic [octc_pkg::TIME_BITS-1:0]      wr_stamp,
    input  logic                                clear_all,
    output octc_pkg::lookup_t                   entry
);
    import octc_pkg::*;

    localparam int ENTRY_W = TIME_BITS + LEVEL_BITS;

    logic [ENTRY_W-1:0]    mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [ENTRY_W-1:0]    byp_data_reg;
    logic                  byp_hit_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [TABLE_SIZE-1:0] vbits_reg;
    logic [TABLE_SIZE-1:0] vbits_next;
    logic [ENTRY_W-1:0]    cur;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_stamp, wr_level};
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= {wr_stamp, wr_level};
            rd_addr_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // A clear and a write in the same cycle: the clear goes first.
    always_comb
    begin
        vbits_next = clear_all ? '0 : vbits_reg;
        if (wr_en)
        begin
            vbits_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg <= '0;
        end
        else
        begin
            vbits_reg <= vbits_next;
        end
    end

    assign cur = byp_hit_reg ? byp_data_reg : rd_data_reg;

    always_comb
    begin
        entry.valid = vbits_reg[rd_addr_reg];
        entry.level = cur[LEVEL_BITS-1:0];
        entry.stamp = cur[ENTRY_W-1:LEVEL_BITS];
    end

endmodule

[src/osc_to_cc_dedup_filter.sv]
// ----------------------------------------------------------------------------
// osc_to_cc_dedup_filter
// Checks decoded control messages, quantises their value and suppresses
// repeats of an unchanged level within the repeat period.
// ----------------------------------------------------------------------------
// The block takes one message transfer per clock while the output is not
// stalled and returns exactly one result transfer for each, in order. A
// message is registered on entry, decoded and quantised in the first stage
// while the per-index table is read, compared against the stored entry in
// the second stage, and the result sits in the output register. The
// sustained rate is one message per cycle while the output is not stalled,
// set by the single table read and write-back in the second stage (a read
// that meets a write to the same entry takes the written data through a
// bypass register). Each stage moves on as soon as the stage after it is free,
// so new messages keep entering while a finished result waits on the output.
// The table is empty after reset and on every rising edge of the recording
// flag; this is done with one valid bit per entry, so no clearing pass is run
// and the block is ready straight after reset. repeat_period_ms may be
// written only while no message is in flight.
module osc_to_cc_dedup_filter #(
    parameter int TABLE_SIZE = 128,
    parameter int LEVELS     = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration: repeat_period_ms
    input  logic                                  cfg_wen,
    input  logic [octc_pkg::PERIOD_BITS-1:0]      cfg_wdata,
    // Message input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // addr_bytes[63:0], addr_len[71:64], arg_count[79:72], value_q16[111:80],
    // time_ms[143:112], recording[144], record_start_ms[176:145], zero pad
    input  logic [octc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // arg_is_float[0]
    input  logic [0:0]                            s_axis_tuser,
    // Result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // valid_message[0], forward[1], record[2], param_index[9:3], level[16:10],
    // event_time_ms[48:17], record_time_ms[80:49], zero pad
    output logic [octc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import octc_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // Configuration register
    logic [PERIOD_BITS-1:0] period_reg;

    // Stage one: the registered message
    logic                   s1_valid_reg;
    logic [IN_TDATA_W-1:0]  s1_data_reg;
    logic                   s1_float_reg;
    logic                   prev_rec_reg;

    // Stage two: decoded message and table lookup
    logic                   s2_valid_reg;
    decode_t                s2_msg_reg;
    logic [TIME_BITS-1:0]   s2_time_reg;
    logic [TIME_BITS-1:0]   s2_start_reg;
    logic                   s2_rec_reg;
    logic                   s2_rise_reg;

    // Output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Stage enables
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic s2_load;
    logic s2_fire;

    decode_t                s1_msg;
    logic                   s1_rec;
    logic                   s1_rise;
    lookup_t                entry;
    logic                   entry_ok;
    logic                   elapsed;
    logic                   same;
    logic                   fwd;
    logic                   rec;
    logic [TIME_BITS:0]     age;
    logic [TIME_BITS-1:0]   rec_time;

    // Each stage advances when the one after it is empty or advancing.
    assign out_en  = !out_valid_reg || m_axis_tready;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s2_load = s1_valid_reg && s2_en;
    assign s2_fire = s2_valid_reg && out_en;

    assign s_axis_tready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wen)
        begin
            period_reg <= cfg_wdata;
        end
    end

    // ---------------- Stage one ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && s_axis_tvalid)
        begin
            s1_data_reg  <= s_axis_tdata;
            s1_float_reg <= s_axis_tuser[0];
        end
    end

    octc_decode #(
        .TABLE_SIZE (TABLE_SIZE),
        .LEVELS     (LEVELS)
    ) u_decode (
        .addr_bytes   (s1_data_reg[63:0]),
        .addr_len     (s1_data_reg[71:64]),
        .arg_count    (s1_data_reg[79:72]),
        .arg_is_float (s1_float_reg),
        .value_q16    ($signed(s1_data_reg[111:80])),
        .msg          (s1_msg)
    );

    // The recording edge is seen on every message, valid or not, in order.
    assign s1_rec  = s1_data_reg[144];
    assign s1_rise = s1_rec && !prev_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_rec_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            prev_rec_reg <= s1_rec;
        end
    end

    // ---------------- Stage two ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_msg_reg   <= s1_msg;
            s2_time_reg  <= s1_data_reg[143:112];
            s2_start_reg <= s1_data_reg[176:145];
            s2_rec_reg   <= s1_rec;
            s2_rise_reg  <= s1_rise;
        end
    end

    octc_table #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s2_load),
        .rd_addr   (s1_msg.idx[IDX_W-1:0]),
        .wr_en     (s2_fire && fwd),
        .wr_addr   (s2_msg_reg.idx[IDX_W-1:0]),
        .wr_level  (s2_msg_reg.level),
        .wr_stamp  (s2_time_reg),
        .clear_all (s2_fire && s2_rise_reg),
        .entry     (entry)
    );

    // A rising recording edge on this message empties the table before the
    // lookup, so its own entry reads as empty.
    assign entry_ok = entry.valid && !s2_rise_reg;
    assign age      = {1'b0, s2_time_reg} - {1'b0, entry.stamp};
    // Time running backwards (borrow out) counts as not elapsed.
    assign elapsed  = !age[TIME_BITS]
                   && (age[TIME_BITS-1:0] >= {{(TIME_BITS-PERIOD_BITS){1'b0}}, period_reg});
    assign same     = entry_ok && (entry.level == s2_msg_reg.level);
    assign fwd      = s2_msg_reg.valid && (!entry_ok || elapsed || !same);
    assign rec      = fwd && s2_rec_reg;
    assign rec_time = s2_time_reg - s2_start_reg;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = s2_msg_reg.valid;
        out_data_next[1]     = fwd;
        out_data_next[2]     = rec;
        out_data_next[9:3]   = s2_msg_reg.idx;
        out_data_next[16:10] = s2_msg_reg.level;
        out_data_next[48:17] = fwd ? s2_time_reg : '0;
        out_data_next[80:49] = rec ? rec_time : '0;
    end

    // ---------------- Output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_record_needs_forward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[2] |-> out_data_reg[1])
        else $error("record raised without forward");

    a_forward_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[1] |-> out_data_reg[0])
        else $error("forward raised for a rejected message");

    a_rejected_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg[0] |-> (out_data_reg[OUT_TDATA_W-1:1] == '0))
        else $error("rejected message carries non-zero fields");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_table_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fire && fwd && s2_load && (s1_msg.idx == s2_msg_reg.idx) && !s1_rise
        |=> entry.valid)
        else $error("entry just written reads as empty");
`endif

endmodule

[dv/osc_to_cc_dedup_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osc_to_cc_dedup_filter_tb
// Self-checking bench for the control-message dedup filter. A short table of
// hand-picked messages is followed by several phases of random traffic, each
// phase under its own repeat period. Every result transfer is compared field
// by field against a written-in result or a behavioural model held in this bench.
// ----------------------------------------------------------------------------
module osc_to_cc_dedup_filter_tb;

    import octc_pkg::*;

    localparam int TABLE_SIZE = 128;
    localparam int LEVELS     = 128;

    // The fixed part of every accepted address: slash, four letters, slash.
    localparam logic [47:0] ADDR_PREFIX = {CH_SLASH, CH_M, CH_I, CH_E, CH_M, CH_SLASH};

    // One decoded control message as it travels on the input stream.
    typedef struct packed {
        logic [63:0]        addr;
        logic [7:0]         len;
        logic [7:0]         argc;
        logic               is_float;
        logic signed [31:0] value;
        logic [31:0]        now;
        logic               rec;
        logic [31:0]        rec_start;
    } msg_t;

    // One result as it leaves on the output stream.
    typedef struct packed {
        logic                  valid;
        logic                  fwd;
        logic                  rec;
        logic [IDX_BITS-1:0]   idx;
        logic [LEVEL_BITS-1:0] level;
        logic [31:0]           ev_time;
        logic [31:0]           rec_time;
    } res_t;

    // A row of the directed table. Where known is set, the result is written
    // in by hand; otherwise the filter model supplies it.
    typedef struct packed {
        msg_t m;
        logic known;
        res_t want;
    } dir_row_t;

    localparam int N_DIRECTED = 26;

    // The first message after reset lands in an empty table, so its result is
    // plain to see. Rows with known cleared are worked out by the model.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // address, len, argc, float, value, time, recording, record start
        // Index 0, zero value, time zero: forwarded into an empty table.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd0, 1'b0, 32'd0},
          1'b1, '{1'b1, 1'b1, 1'b0, 7'd0, 7'd0, 32'd0, 32'd0}},
        // Same level 10 ms later, well inside the reset period: suppressed.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd10, 1'b0, 32'd0},
          1'b1, '{1'b1, 1'b0, 1'b0, 7'd0, 7'd0, 32'd0, 32'd0}},
        // Highest index, largest value and latest time.
        '{'{{ADDR_PREFIX, "99"}, 8'd8, 8'd1, 1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0},
          1'b1, '{1'b1, 1'b1, 1'b0, 7'd99, 7'd127, 32'hFFFFFFFF, 32'd0}},
        // Most negative value clamps to level zero.
        '{'{{ADDR_PREFIX, "5", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h80000000, 32'd20, 1'b0, 32'd0},
          1'b1, '{1'b1, 1'b1, 1'b0, 7'd5, 7'd0, 32'd20, 32'd0}},
        // Exactly 1.0 maps to the top level.
        '{'{{ADDR_PREFIX, "1", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h00010000, 32'd30, 1'b0, 32'd0},
          1'b1, '{1'b1, 1'b1, 1'b0, 7'd1, 7'd127, 32'd30, 32'd0}},
        // Half scale, then either side of the first rounding step, then -1 lsb.
        '{'{{ADDR_PREFIX, "2", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h00008000, 32'd40, 1'b0, 32'd0},
          1'b0, '0},
        '{'{{ADDR_PREFIX, "3", 8'h00}, 8'd7, 8'd1, 1'b1, 32'd258, 32'd41, 1'b0, 32'd0},
          1'b0, '0},
        '{'{{ADDR_PREFIX, "4", 8'h00}, 8'd7, 8'd1, 1'b1, 32'd259, 32'd42, 1'b0, 32'd0},
          1'b0, '0},
        '{'{{ADDR_PREFIX, "6", 8'h00}, 8'd7, 8'd1, 1'b1, 32'hFFFFFFFF, 32'd43, 1'b0, 32'd0},
          1'b0, '0},
        // Rejections: argument count, argument type, length, prefix, digits.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd0, 1'b1, 32'h0, 32'd44, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd255, 1'b1, 32'h0, 32'd45, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b0, 32'h0, 32'd46, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd6, 8'd1, 1'b1, 32'h0, 32'd47, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "12"}, 8'd9, 8'd1, 1'b1, 32'h0, 32'd48, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "12"}, 8'd255, 8'd1, 1'b1, 32'h0, 32'd49, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{CH_SLASH, CH_M, CH_I, CH_E, "x", CH_SLASH, "1", 8'h00}, 8'd7, 8'd1, 1'b1,
            32'h0, 32'd50, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, ":", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd51, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "1/"}, 8'd8, 8'd1, 1'b1, 32'h0, 32'd52, 1'b0, 32'd0},
          1'b1, '0},
        // One-digit address with a junk trailing byte: the byte is not looked at.
        '{'{{ADDR_PREFIX, "7", 8'hFF}, 8'd7, 8'd1, 1'b1, 32'h00004000, 32'd53, 1'b0, 32'd0},
          1'b0, '0},
        // Recording starts: the table is emptied, so index 0 goes through again.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd100, 1'b1, 32'd5},
          1'b0, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd110, 1'b1, 32'd5},
          1'b0, '0},
        // Time running backwards never counts as the period having passed.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h0, 32'd60, 1'b1, 32'd5},
          1'b0, '0},
        // New level, and a time before the recording start: negative offset.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h00010000, 32'd3, 1'b1, 32'd10},
          1'b0, '0},
        // Recording drops and rises again on rejected messages; the table is
        // still cleared, so an unchanged level on index 0 is forwarded.
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd0, 1'b1, 32'h0, 32'd4, 1'b0, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd0, 1'b1, 32'h0, 32'd4, 1'b1, 32'd0},
          1'b1, '0},
        '{'{{ADDR_PREFIX, "0", 8'h00}, 8'd7, 8'd1, 1'b1, 32'h00010000, 32'd5, 1'b1, 32'd5},
          1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [PERIOD_BITS-1:0] cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Bench copy of the filter state and of the repeat period register.
    logic [LEVEL_BITS-1:0]  held_level [TABLE_SIZE] = '{default: '0};
    logic [31:0]            held_stamp [TABLE_SIZE] = '{default: '0};
    logic [TABLE_SIZE-1:0]  live_mask = '0;
    logic                   rec_seen = 1'b0;
    logic [PERIOD_BITS-1:0] period_ms = PERIOD_RESET;

    // Results owed by the block, oldest first.
    res_t awaited_outcomes [$];
    int   error_count = 0;

    // Traffic shaping shared between the sender and the receiver.
    bit   calm = 1'b0;      // no idling on either side while set
    bit   hold_req = 1'b0;  // asks the receiver for one long hold-off
    int   hold_left = 0;

    // Running state of the random traffic.
    logic [31:0] clock_ms = 32'd1000;
    logic        rec_on = 1'b1;
    logic [31:0] rec_base = 32'd10;

    osc_to_cc_dedup_filter #(
        .TABLE_SIZE (TABLE_SIZE),
        .LEVELS     (LEVELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Behavioural model of the filter: decodes the message, quantises its
    // value, applies the duplicate test and updates the bench table.
    function automatic res_t dedup_decision(msg_t m);
        res_t       r;
        logic [7:0] c6;
        logic [7:0] c7;
        logic       ok;
        int         n;
        longint     p;
        logic       elapsed;
        logic       same;
        r  = '0;
        c6 = m.addr[15:8];
        c7 = m.addr[7:0];
        // The recording edge is seen on every message, accepted or not.
        if (m.rec && !rec_seen)
            live_mask = '0;
        rec_seen = m.rec;

        ok = m.argc == ARGS_EXPECTED && m.is_float
             && (m.len == LEN_ONE_DIGIT || m.len == LEN_TWO_DIGIT)
             && m.addr[63:16] == ADDR_PREFIX && c6 >= CH_0 && c6 <= CH_9;
        n = int'(c6) - int'(CH_0);
        if (ok && m.len == LEN_TWO_DIGIT)
        begin
            if (c7 >= CH_0 && c7 <= CH_9)
                n = n * 10 + int'(c7) - int'(CH_0);
            else
                ok = 1'b0;
        end
        if (!ok || n >= TABLE_SIZE)
            return r;

        r.valid = 1'b1;
        r.idx   = n[IDX_BITS-1:0];
        // Round half up of (LEVELS-1) * v in Q15.16, then clamp.
        p = longint'(LEVELS - 1) * longint'($signed(m.value)) + 64'sh8000;
        if (p < 0)
            r.level = '0;
        else if ((p >>> 16) > LEVELS - 1)
            r.level = LEVEL_BITS'(LEVELS - 1);
        else
            r.level = p[16 +: LEVEL_BITS];

        elapsed = m.now >= held_stamp[n] && (m.now - held_stamp[n]) >= 32'(period_ms);
        same    = live_mask[n] && held_level[n] == r.level;
        if (!live_mask[n] || elapsed || !same)
        begin
            r.fwd         = 1'b1;
            r.ev_time     = m.now;
            held_stamp[n] = m.now;
            held_level[n] = r.level;
            live_mask[n]  = 1'b1;
            if (m.rec)
            begin
                r.rec      = 1'b1;
                r.rec_time = m.now - m.rec_start;
            end
        end
        return r;
    endfunction

    task automatic flag_error(string what);
        $display("ERROR @%0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] seen, logic [31:0] want);
        if (seen !== want)
            flag_error($sformatf("%s is 0x%0h, should be 0x%0h", name, seen, want));
    endtask

    // Offers one message, at times after a random gap, and records the result it
    // owes once the transfer is taken. tvalid stays high on return so that
    // the next message can follow back to back.
    task automatic send_message(msg_t m, logic known, res_t want);
        res_t r;
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, m.rec_start, m.rec, m.now, m.value, m.argc, m.len, m.addr};
        s_axis_tuser  <= m.is_float;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = dedup_decision(m);
        if (known)
            r = want;
        awaited_outcomes.insert(awaited_outcomes.size(), r);
    endtask

    // Lets every owed result come back, then lets the block idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(logic [PERIOD_BITS-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        period_ms = v;
    endtask

    // Random traffic. Most messages are well formed on a few busy indices
    // with values on a coarse grid, so repeats and suppressions are common;
    // the rest are broken on one point or are plain noise.
    task automatic run_phase(int count, logic [PERIOD_BITS-1:0] period, bit squeeze);
        msg_t       m;
        int         n;
        int         gap;
        int         pick;
        int         pos;
        logic [7:0] ch;
        gap = int'(period) / 2 + 3;
        for (int i = 0; i < count; i++)
        begin
            if (squeeze && i == 40)
                hold_req = 1'b1;

            if ($urandom_range(0, 99) < 4)
            begin
                rec_on = !rec_on;
                if (rec_on)
                    rec_base = $urandom_range(0, 1) ? clock_ms - $urandom_range(0, 5000)
                                                    : $urandom;
            end

            pick = $urandom_range(0, 99);
            if (pick < 85)
                clock_ms += $urandom_range(0, gap);
            else if (pick < 93)
                clock_ms -= $urandom_range(1, gap);
            else
                clock_ms = $urandom;

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: m.value = $urandom_range(0, 4) * 32'h4000;
                6:                m.value = $urandom;
                7:                m.value = $urandom_range(0, 32'h10000);
                8:                m.value = -$urandom_range(1, 32'h20000);
                default:          m.value = $urandom_range(32'h10000, 32'h7FFFFFFF);
            endcase

            n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 99);
            if (n < 10 && $urandom_range(0, 1))
            begin
                m.len  = LEN_ONE_DIGIT;
                m.addr = {ADDR_PREFIX, 8'(CH_0 + n),
                          $urandom_range(0, 1) ? 8'($urandom) : 8'h00};
            end
            else
            begin
                m.len  = LEN_TWO_DIGIT;
                m.addr = {ADDR_PREFIX, 8'(CH_0 + n / 10), 8'(CH_0 + n % 10)};
            end
            m.argc      = ARGS_EXPECTED;
            m.is_float  = 1'b1;
            m.now       = clock_ms;
            m.rec       = rec_on;
            m.rec_start = rec_base;

            pick = $urandom_range(0, 99);
            if (pick >= 88)
            begin
                m.addr      = {$urandom, $urandom};
                m.len       = 8'($urandom_range(0, 255));
                m.argc      = $urandom_range(0, 1) ? ARGS_EXPECTED : 8'($urandom);
                m.is_float  = 1'($urandom_range(0, 1));
                m.value     = $urandom;
                m.now       = $urandom;
                m.rec_start = $urandom;
            end
            else if (pick >= 80)
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        do
                            m.argc = 8'($urandom);
                        while (m.argc == ARGS_EXPECTED);
                    end
                    1: m.is_float = 1'b0;
                    2:
                    begin
                        do
                            m.len = 8'($urandom);
                        while (m.len == LEN_ONE_DIGIT || m.len == LEN_TWO_DIGIT);
                    end
                    3:
                    begin
                        pos = $urandom_range(0, 5);
                        m.addr[63 - 8 * pos -: 8] ^= 8'($urandom_range(1, 255));
                    end
                    default:
                    begin
                        pos = (m.len == LEN_TWO_DIGIT && $urandom_range(0, 1)) ? 7 : 6;
                        do
                            ch = 8'($urandom);
                        while (ch >= CH_0 && ch <= CH_9);
                        m.addr[63 - 8 * pos -: 8] = ch;
                    end
                endcase
            end

            send_message(m, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, none while calm, and one long hold-off on
    // request so that the block fills up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 80;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // Every result transfer is matched against the oldest owed result.
    always @(posedge clk)
    begin : result_check
        res_t seen;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.valid    = m_axis_tdata[0];
            seen.fwd      = m_axis_tdata[1];
            seen.rec      = m_axis_tdata[2];
            seen.idx      = m_axis_tdata[9:3];
            seen.level    = m_axis_tdata[16:10];
            seen.ev_time  = m_axis_tdata[48:17];
            seen.rec_time = m_axis_tdata[80:49];
            if (awaited_outcomes.size() == 0)
                flag_error("result transfer with no message outstanding");
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("valid_message", 32'(seen.valid), 32'(want.valid));
                check_field("forward", 32'(seen.fwd), 32'(want.fwd));
                check_field("record", 32'(seen.rec), 32'(want.rec));
                check_field("param_index", 32'(seen.idx), 32'(want.idx));
                check_field("level", 32'(seen.level), 32'(want.level));
                check_field("event_time_ms", seen.ev_time, want.ev_time);
                check_field("record_time_ms", seen.rec_time, want.rec_time);
            end
        end
    end

    initial
    begin
        logic [PERIOD_BITS-1:0] periods [7];
        periods = '{16'd0, 16'hFFFF, 16'd1, PERIOD_RESET,
                    16'($urandom_range(2, 2000)), 16'($urandom), 16'd50};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run under the reset value of the repeat period.
        for (int i = 0; i < N_DIRECTED; i++)
            send_message(DIRECTED[i].m, DIRECTED[i].known, DIRECTED[i].want);

        // Random phases, each with its own period. The third phase carries
        // the long receiver hold-off; the fifth runs with no idling at all.
        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            write_period(periods[ph]);
            calm = (ph == 4);
            run_phase(200, periods[ph], ph == 2);
        end
        calm = 1'b0;
        settle();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("PASS osc_to_cc_dedup_filter");
        else
            $display("FAIL osc_to_cc_dedup_filter");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #(5_000_000);
        $display("FAIL osc_to_cc_dedup_filter");
        $finish;
    end

endmodule

[files.f]
src/octc_pkg.sv
src/octc_decode.sv
src/octc_table.sv
src/osc_to_cc_dedup_filter.sv
dv/osc_to_cc_dedup_filter_tb.sv
